FILE: design/value_searchable_queue_core_macros.svh
// assertion macros shared by the queue core modules
// no dependencies; included by the files that carry concurrent checks
`ifndef VALUE_SEARCHABLE_QUEUE_CORE_MACROS_SVH
`define VALUE_SEARCHABLE_QUEUE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// checked property, disabled while reset is high
`define VSQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also active during reset
`define VSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VSQ_ASSERT(lbl, clk, rst, prop, msg)
`define VSQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/vsq_pkg.sv
// shared types, codes and constants of the value searchable queue core
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package vsq_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 16;

   // action codes
   localparam logic [2:0] ACT_INSERT  = 3'd0;
   localparam logic [2:0] ACT_SEARCH  = 3'd1;
   localparam logic [2:0] ACT_MODIFY  = 3'd2;
   localparam logic [2:0] ACT_DELETE  = 3'd3;
   localparam logic [2:0] ACT_DISPLAY = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // write address select
   localparam logic [1:0] WA_TAIL = 2'd0;
   localparam logic [1:0] WA_CUR  = 2'd1;
   localparam logic [1:0] WA_PREV = 2'd2;

   // write data select
   localparam logic [1:0] WD_KEY   = 2'd0;
   localparam logic [1:0] WD_NEW   = 2'd1;
   localparam logic [1:0] WD_RDATA = 2'd2;

   // result value select
   localparam logic [1:0] EV_KEY   = 2'd0;
   localparam logic [1:0] EV_NEW   = 2'd1;
   localparam logic [1:0] EV_RDATA = 2'd2;
   localparam logic [1:0] EV_ZERO  = 2'd3;

   typedef struct packed {
      logic [2:0]               action;
      logic signed [DATA_W-1:0] key_value;
      logic signed [DATA_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] item_value;
      logic                     last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       idx_clear;
      logic       idx_inc;
      logic       rd_next;
      logic       wr_en;
      logic [1:0] wr_addr_sel;
      logic [1:0] wr_data_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       emit;
      logic [1:0] emit_status;
      logic [1:0] emit_val_sel;
      logic       emit_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] action;
      logic       cnt_zero;
      logic       full;
      logic       match;
      logic       at_tail;
   } stat_type;

endpackage

FILE: design/vsq_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies; used for the queue entry store
`timescale 1ns / 1ps

module vsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/vsq_ctrl.sv
// controller state machine of the queue core: sequences inserts, scans and shifts
// depends on vsq_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "value_searchable_queue_core_macros.svh"

module vsq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vsq_pkg::stat_type stat,
   output vsq_pkg::cmd_type  cmd
);

   import vsq_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            // read address stays at the head so entry 0 is ready in the next cycle
            if (start) begin
               cmd.load_req  = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (stat.action == ACT_INSERT) begin
               cmd.emit         = 1'b1;
               cmd.emit_last    = 1'b1;
               cmd.emit_val_sel = EV_KEY;
               if (stat.full) begin
                  cmd.emit_status = ST_FULL;
               end else begin
                  cmd.emit_status = ST_OK;
                  cmd.wr_en       = 1'b1;
                  cmd.wr_addr_sel = WA_TAIL;
                  cmd.wr_data_sel = WD_KEY;
                  cmd.cnt_inc     = 1'b1;
               end
            end else if (stat.action inside {ACT_SEARCH, ACT_MODIFY, ACT_DELETE,
                                             ACT_DISPLAY}) begin
               if (stat.cnt_zero) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_last    = 1'b1;
                  cmd.emit_status  = ST_EMPTY;
                  cmd.emit_val_sel = EV_ZERO;
               end else if (stat.action == ACT_DISPLAY) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_status  = ST_OK;
                  cmd.emit_val_sel = EV_RDATA;
                  cmd.emit_last    = stat.at_tail;
                  if (!stat.at_tail) begin
                     cmd.idx_inc = 1'b1;
                     cmd.rd_next = 1'b1;
                     state_in    = S_EXEC;
                  end
               end else if (stat.match) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = ST_OK;
                  if (stat.action == ACT_MODIFY) begin
                     cmd.emit_val_sel = EV_NEW;
                     cmd.wr_en        = 1'b1;
                     cmd.wr_addr_sel  = WA_CUR;
                     cmd.wr_data_sel  = WD_NEW;
                  end else begin
                     cmd.emit_val_sel = EV_KEY;
                     if (stat.action == ACT_DELETE) begin
                        if (stat.at_tail) begin
                           cmd.cnt_dec = 1'b1;
                        end else begin
                           // result goes out once the later entries have moved up
                           cmd.emit    = 1'b0;
                           cmd.idx_inc = 1'b1;
                           cmd.rd_next = 1'b1;
                           state_in    = S_SHIFT;
                        end
                     end
                  end
               end else if (stat.at_tail) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_last    = 1'b1;
                  cmd.emit_status  = ST_NOTFOUND;
                  cmd.emit_val_sel = EV_KEY;
               end else begin
                  cmd.idx_inc = 1'b1;
                  cmd.rd_next = 1'b1;
                  state_in    = S_EXEC;
               end
            end
         end
         S_SHIFT: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = WA_PREV;
            cmd.wr_data_sel = WD_RDATA;
            if (stat.at_tail) begin
               cmd.cnt_dec      = 1'b1;
               cmd.emit         = 1'b1;
               cmd.emit_last    = 1'b1;
               cmd.emit_status  = ST_OK;
               cmd.emit_val_sel = EV_KEY;
               state_in         = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               cmd.rd_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `VSQ_ASSERT(a_no_emit_idle, clock, reset, (state_ff == S_IDLE) |-> !cmd.emit,
               "result issued while idle")
   `VSQ_ASSERT(a_busy_after_start, clock, reset, (start && !busy) |=> busy,
               "transfer accepted but controller not busy")
   `VSQ_ASSERT(a_shift_entry, clock, reset,
               (state_ff == S_SHIFT) |-> ($past(state_ff) == S_EXEC || $past(state_ff) == S_SHIFT),
               "shift entered from idle")

endmodule

FILE: design/vsq_datapath.sv
// datapath of the queue core: request latch, entry ram, scan index, fill count
// and result register; depends on vsq_pkg, vsq_ram and the assertion macro header
`timescale 1ns / 1ps
`include "value_searchable_queue_core_macros.svh"

module vsq_datapath #(
   parameter int DEPTH = vsq_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  vsq_pkg::req_type  req_data,
   input  vsq_pkg::cmd_type  cmd,
   output vsq_pkg::stat_type stat,
   output logic              rsp_valid,
   output vsq_pkg::rsp_type  rsp_data
);

   import vsq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

   req_type          req_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   vsq_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // next entry is fetched while the current one is examined
   assign rd_addr = cmd.rd_next ? (idx_ff + IDX_W'(1)) : '0;

   always_comb begin
      case (cmd.wr_addr_sel)
         WA_TAIL: wr_addr = cnt_ff[IDX_W-1:0];
         WA_CUR:  wr_addr = idx_ff;
         WA_PREV: wr_addr = idx_ff - IDX_W'(1);
         default: wr_addr = idx_ff;
      endcase
      case (cmd.wr_data_sel)
         WD_KEY:   wr_data = req_ff.key_value;
         WD_NEW:   wr_data = req_ff.new_value;
         WD_RDATA: wr_data = rd_data;
         default:  wr_data = rd_data;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      cnt_in = cnt_ff;
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in.status = cmd.emit_status;
      rsp_in.last   = cmd.emit_last;
      case (cmd.emit_val_sel)
         EV_KEY:   rsp_in.item_value = req_ff.key_value;
         EV_NEW:   rsp_in.item_value = req_ff.new_value;
         EV_RDATA: rsp_in.item_value = $signed(rd_data);
         EV_ZERO:  rsp_in.item_value = '0;
         default:  rsp_in.item_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
      idx_ff <= idx_in;
   end

   assign stat.action   = req_ff.action;
   assign stat.cnt_zero = (cnt_ff == '0);
   assign stat.full     = (cnt_ff == CNT_MAX);
   assign stat.match    = (rd_data == $unsigned(req_ff.key_value));
   assign stat.at_tail  = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `VSQ_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_MAX,
               "fill count above queue depth")
   `VSQ_ASSERT(a_cnt_one_way, clock, reset, !(cmd.cnt_inc && cmd.cnt_dec),
               "fill count raised and lowered together")
   `VSQ_ASSERT(a_wr_in_range, clock, reset, cmd.wr_en |-> (CNT_W'(wr_addr) <= cnt_ff),
               "entry write beyond the tail")

endmodule

FILE: design/value_searchable_queue_core.sv
// top level of the value searchable queue core: controller plus datapath
// depends on vsq_pkg, vsq_ctrl, vsq_datapath
//
//   channel   ports                          transfer when
//   request   start, busy, req_data          start high and busy low at a rising edge
//   result    rsp_valid, rsp_data            rsp_valid high, one cycle per result
//
// an insert, or any action on an empty queue, is done in the exec state alone;
// search, modify, delete and display walk the entry ram one entry a cycle
// through its single read port, so busy stays high while the walk lasts;
// unknown actions give no result.
// reset is synchronous and empties the queue; entry contents are not cleared.
// results are strobed for one cycle and cannot be held off by the receiver.
`timescale 1ns / 1ps

module value_searchable_queue_core #(
   parameter int DEPTH = vsq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vsq_pkg::req_type req_data,
   output logic             rsp_valid,
   output vsq_pkg::rsp_type rsp_data
);

   import vsq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   vsq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   vsq_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

FILE: test/tb.sv
// testbench for value_searchable_queue_core: directed and random request streams
// a scoreboard class predicts every result; depends on vsq_pkg and the core RTL
`timescale 1ns / 1ps

module tb;
   import vsq_pkg::*;

   localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 210;
   localparam int IDLE_LIMIT   = 2000;

   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

   // codes above display are not defined and must be ignored by the core
   localparam logic [2:0] ACT_RESERVED_5 = 3'd5;
   localparam logic [2:0] ACT_RESERVED_6 = 3'd6;
   localparam logic [2:0] ACT_RESERVED_7 = 3'd7;

   class queue_scoreboard;
      logic signed [DATA_W-1:0] contents[$];
      rsp_type                  awaited[$];
      int errors;
      int requests;
      int ignored;
      int checked;
      int full_refusals;
      int empty_replies;
      int peak_fill;

      function new();
         errors        = 0;
         requests      = 0;
         ignored       = 0;
         checked       = 0;
         full_refusals = 0;
         empty_replies = 0;
         peak_fill     = 0;
      endfunction

      function void push_awaited(logic [1:0] status, logic signed [DATA_W-1:0] value,
                                 logic last_flag);
         rsp_type r;
         r.status     = status;
         r.item_value = value;
         r.last       = last_flag;
         awaited.push_back(r);
      endfunction

      // apply one accepted request to the queue image and queue up its results
      function void note_request(req_type r);
         int pos;
         pos = -1;
         requests++;
         if (r.action == ACT_INSERT) begin
            if (contents.size() >= DEPTH_DEFAULT) begin
               full_refusals++;
               push_awaited(ST_FULL, r.key_value, 1'b1);
            end else begin
               contents.push_back(r.key_value);
               push_awaited(ST_OK, r.key_value, 1'b1);
               if (contents.size() > peak_fill) peak_fill = contents.size();
            end
         end else if (r.action > ACT_DISPLAY) begin
            ignored++;
         end else if (contents.size() == 0) begin
            empty_replies++;
            push_awaited(ST_EMPTY, '0, 1'b1);
         end else if (r.action == ACT_DISPLAY) begin
            foreach (contents[i])
               push_awaited(ST_OK, contents[i], i == contents.size() - 1);
         end else begin
            foreach (contents[i])
               if (pos < 0 && contents[i] == r.key_value) pos = i;
            if (pos < 0) begin
               push_awaited(ST_NOTFOUND, r.key_value, 1'b1);
            end else begin
               case (r.action)
                  ACT_SEARCH: begin
                     push_awaited(ST_OK, r.key_value, 1'b1);
                  end
                  ACT_MODIFY: begin
                     contents[pos] = r.new_value;
                     push_awaited(ST_OK, r.new_value, 1'b1);
                  end
                  default: begin
                     // delete closes the gap, order of the rest is kept
                     contents.delete(pos);
                     push_awaited(ST_OK, r.key_value, 1'b1);
                  end
               endcase
            end
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            $error("unexpected result: status %0d item_value %0d last %0d",
                   got.status, got.item_value, got.last);
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, got.status);
         end
         if (got.item_value !== want.item_value) begin
            errors++;
            $error("item_value: expected %0d, got %0d", want.item_value, got.item_value);
         end
         if (got.last !== want.last) begin
            errors++;
            $error("last: expected %0d, got %0d", want.last, got.last);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   queue_scoreboard queue_sb = new();
   int idle_cycles = 0;

   value_searchable_queue_core #(
      .DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) queue_sb.check_result(rsp_data);
   end

   // stall watchdog: no request and no result transfer for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, queue_sb.pending());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_req(logic [2:0] action, logic signed [DATA_W-1:0] key,
                                        logic signed [DATA_W-1:0] repl);
      req_type r;
      r.action    = action;
      r.key_value = key;
      r.new_value = repl;
      return r;
   endfunction

   // narrow range a third of the time so duplicates and hits are common
   function automatic logic signed [DATA_W-1:0] pick_value();
      int v;
      case ($urandom_range(0, 5))
         0, 1: v = int'($urandom_range(0, 7)) - 4;
         2: begin
            case ($urandom_range(0, 3))
               0:       v = MOST_NEGATIVE;
               1:       v = MOST_POSITIVE;
               2:       v = 0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_key();
      int n;
      n = queue_sb.contents.size();
      if (n > 0 && $urandom_range(0, 9) < 7) return queue_sb.contents[$urandom_range(0, n - 1)];
      return pick_value();
   endfunction

   // mode 0 grows the queue toward full, 1 is balanced, 2 drains it
   function automatic req_type next_random(int mode);
      req_type     r;
      int unsigned roll;
      int          ins_w;
      int          del_w;
      case (mode)
         0:       begin ins_w = 70; del_w = 6;  end
         1:       begin ins_w = 35; del_w = 25; end
         default: begin ins_w = 15; del_w = 45; end
      endcase
      roll        = $urandom_range(0, 99);
      r.key_value = pick_key();
      r.new_value = pick_value();
      if (roll < ins_w) begin
         r.action    = ACT_INSERT;
         r.key_value = pick_value();
      end else if (roll < ins_w + del_w) begin
         r.action = ACT_DELETE;
      end else if (roll < ins_w + del_w + 8) begin
         r.action = ACT_DISPLAY;
      end else if (roll < ins_w + del_w + 12) begin
         case ($urandom_range(0, 2))
            0:       r.action = ACT_RESERVED_5;
            1:       r.action = ACT_RESERVED_6;
            default: r.action = ACT_RESERVED_7;
         endcase
      end else if (roll[0]) begin
         r.action = ACT_SEARCH;
      end else begin
         r.action = ACT_MODIFY;
      end
      return r;
   endfunction

   // returns in the time step of the transfer; start stays high for back-to-back items
   task automatic issue(input req_type r, input int gap);
      if (start && gap == 0) begin
         req_data <= r;
      end else begin
         if (start) start <= 1'b0;
         repeat (gap) @(posedge clock);
         start    <= 1'b1;
         req_data <= r;
      end
      do @(posedge clock); while (busy);
      queue_sb.note_request(r);
   endtask

   initial begin
      req_type directed[$];
      req_type r;
      int      counted;
      int      gap;
      bit      no_idle;

      directed.push_back(make_req(ACT_DISPLAY, 0, 0));
      directed.push_back(make_req(ACT_SEARCH, 7, 0));
      directed.push_back(make_req(ACT_MODIFY, 7, 1));
      directed.push_back(make_req(ACT_DELETE, 7, 0));
      directed.push_back(make_req(ACT_INSERT, 5, 0));
      directed.push_back(make_req(ACT_DELETE, 5, 0));
      directed.push_back(make_req(ACT_SEARCH, 5, 0));
      directed.push_back(make_req(ACT_INSERT, MOST_NEGATIVE, MOST_POSITIVE));
      directed.push_back(make_req(ACT_INSERT, MOST_POSITIVE, MOST_NEGATIVE));
      directed.push_back(make_req(ACT_INSERT, -1, 0));
      directed.push_back(make_req(ACT_INSERT, -1, 0));
      directed.push_back(make_req(ACT_SEARCH, -1, 0));
      directed.push_back(make_req(ACT_SEARCH, 0, 0));
      directed.push_back(make_req(ACT_MODIFY, -1, 0));
      directed.push_back(make_req(ACT_MODIFY, 3, 9));
      directed.push_back(make_req(ACT_DELETE, MOST_NEGATIVE, 0));
      directed.push_back(make_req(ACT_DELETE, 3, 0));
      directed.push_back(make_req(ACT_RESERVED_5, -1, -1));
      directed.push_back(make_req(ACT_RESERVED_6, 0, 0));
      directed.push_back(make_req(ACT_RESERVED_7, MOST_POSITIVE, MOST_NEGATIVE));
      directed.push_back(make_req(ACT_DISPLAY, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      no_idle = 1'b0;
      foreach (directed[i]) begin
         if (i % 7 == 0) no_idle = ($urandom_range(0, 2) == 0);
         gap = no_idle ? 0 : $urandom_range(0, 12);
         issue(directed[i], gap);
      end

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted % 20 == 0) no_idle = ($urandom_range(0, 2) == 0);
         r   = next_random((counted / 35) % 3);
         gap = no_idle ? 0 : $urandom_range(0, 12);
         issue(r, gap);
         if (r.action <= ACT_DISPLAY) counted++;
      end
      start <= 1'b0;

      while (queue_sb.pending() != 0) @(posedge clock);
      repeat (QUEUE_DEPTH + 4) @(posedge clock);

      $display("covered %0d requests (%0d with undefined action), %0d results checked",
               queue_sb.requests, queue_sb.ignored, queue_sb.checked);
      $display("refused inserts on full %0d, replies on empty %0d, peak fill %0d of %0d",
               queue_sb.full_refusals, queue_sb.empty_replies, queue_sb.peak_fill,
               QUEUE_DEPTH);
      if (queue_sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
